// File: hdl/cclt_pkg.sv
// shared types and constants for the character counting link tracker
package cclt_pkg;

    localparam int RING_LINES_DEF   = 16;
    localparam int PREFIX_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_SEND    = 2'd1,
        OP_RESET   = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_RX_BUFFER_SIZE = 2'd0,
        CFG_POLL_INTERVAL  = 2'd1,
        CFG_LINK_TIMEOUT   = 2'd2
    } cfg_index_t;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_STATUS = 3'd1;
    localparam logic [2:0] KIND_OK     = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_ALARM  = 3'd4;
    localparam logic [2:0] KIND_BANNER = 3'd5;
    localparam logic [2:0] KIND_OTHER  = 3'd6;

    localparam logic [3:0] MS_UNKNOWN = 4'd0;
    localparam logic [3:0] MS_IDLE    = 4'd1;
    localparam logic [3:0] MS_RUN     = 4'd2;
    localparam logic [3:0] MS_HOLD    = 4'd3;
    localparam logic [3:0] MS_JOG     = 4'd4;
    localparam logic [3:0] MS_ALARM   = 4'd5;
    localparam logic [3:0] MS_DOOR    = 4'd6;
    localparam logic [3:0] MS_CHECK   = 4'd7;
    localparam logic [3:0] MS_HOME    = 4'd8;
    localparam logic [3:0] MS_SLEEP   = 4'd9;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // classified item handed from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] len;
        logic [2:0] kind;
        logic       tok_set;
        logic [3:0] tok_state;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic       accepted;
        logic [2:0] line_kind;
        logic [3:0] machine_state;
        logic       link_up;
        logic [7:0] free_credit;
        logic [4:0] lines_outstanding;
        logic       send_unlock;
        logic       send_poll;
        logic       send_reset_byte;
    } res_t;

endpackage

// File: hdl/cclt_front.sv
// front end: line assembly and classification of incoming items
module cclt_front #(
    parameter int PREFIX_BYTES = cclt_pkg::PREFIX_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [1:0]     operation,
    input  logic [7:0]     rx_byte,
    input  logic [7:0]     line_length,
    output cclt_pkg::cmd_t cmd
);
    import cclt_pkg::*;

    localparam int PW = $clog2(PREFIX_BYTES);

    logic [7:0] prefix_reg [PREFIX_BYTES];
    logic [7:0] count_reg;

    function automatic logic [7:0] ch(input logic [7:0] pf [PREFIX_BYTES],
                                      input logic [7:0] cnt, input int i);
        logic [7:0] r;
        if (8'(i) >= cnt)
            r = 8'h00;
        else if (i >= PREFIX_BYTES)
            r = 8'hFF;
        else
            r = pf[i];
        return r;
    endfunction

    logic [7:0] c [13];
    always_comb
    begin
        for (int i = 0; i < 13; i++)
            c[i] = ch(prefix_reg, count_reg, i);
    end

    function automatic logic tend(input logic [7:0] x);
        return x == 8'h00 || x == "|" || x == ">";
    endfunction

    logic       eol;
    logic [3:0] tok;
    logic       tok_set;
    logic [2:0] kind;

    always_comb
    begin
        eol = operation == OP_RX_BYTE && (rx_byte == CH_LF || rx_byte == CH_CR)
              && count_reg != 8'd0;
        tok_set = !tend(c[1]);
        if (c[1] == "I" && c[2] == "d" && c[3] == "l" && c[4] == "e" && tend(c[5]))
            tok = MS_IDLE;
        else if (c[1] == "R" && c[2] == "u" && c[3] == "n" && tend(c[4]))
            tok = MS_RUN;
        else if (c[1] == "H" && c[2] == "o" && c[3] == "l" && c[4] == "d"
                 && (tend(c[5]) || c[5] == ":"))
            tok = MS_HOLD;
        else if (c[1] == "J" && c[2] == "o" && c[3] == "g" && tend(c[4]))
            tok = MS_JOG;
        else if (c[1] == "A" && c[2] == "l" && c[3] == "a" && c[4] == "r" && c[5] == "m"
                 && tend(c[6]))
            tok = MS_ALARM;
        else if (c[1] == "D" && c[2] == "o" && c[3] == "o" && c[4] == "r"
                 && (tend(c[5]) || c[5] == ":"))
            tok = MS_DOOR;
        else if (c[1] == "C" && c[2] == "h" && c[3] == "e" && c[4] == "c" && c[5] == "k"
                 && tend(c[6]))
            tok = MS_CHECK;
        else if (c[1] == "H" && c[2] == "o" && c[3] == "m" && c[4] == "e" && tend(c[5]))
            tok = MS_HOME;
        else if (c[1] == "S" && c[2] == "l" && c[3] == "e" && c[4] == "e" && c[5] == "p"
                 && tend(c[6]))
            tok = MS_SLEEP;
        else
            tok = MS_UNKNOWN;

        if (!eol)
            kind = KIND_NONE;
        else if (c[0] == "<")
            kind = KIND_STATUS;
        else if (c[0] == "o" && c[1] == "k" && c[2] == 8'h00)
            kind = KIND_OK;
        else if (c[0] == "e" && c[1] == "r" && c[2] == "r" && c[3] == "o" && c[4] == "r"
                 && c[5] == ":")
            kind = KIND_ERROR;
        else if (c[0] == "A" && c[1] == "L" && c[2] == "A" && c[3] == "R" && c[4] == "M"
                 && c[5] == ":")
            kind = KIND_ALARM;
        else if (c[0] == "G" && c[1] == "r" && c[2] == "b" && c[3] == "l" && c[4] == " ")
            kind = KIND_BANNER;
        else
            kind = KIND_OTHER;

        cmd.op        = op_t'(operation);
        cmd.len       = line_length;
        cmd.kind      = kind;
        cmd.tok_set   = tok_set;
        cmd.tok_state = tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 8'd0;
        else if (take)
        begin
            if (operation == OP_RESET)
                count_reg <= 8'd0;
            else if (operation == OP_RX_BYTE)
            begin
                if (rx_byte == CH_LF || rx_byte == CH_CR)
                    count_reg <= 8'd0;
                else if (count_reg != 8'hFF)
                    count_reg <= count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && operation == OP_RX_BYTE && rx_byte != CH_LF && rx_byte != CH_CR
            && count_reg < 8'(PREFIX_BYTES))
            prefix_reg[count_reg[PW-1:0]] <= rx_byte;
    end

endmodule

// File: hdl/cclt_queue.sv
// short fifo used between front and back and for results
module cclt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    import cclt_pkg::*;

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full  = cnt_reg == 2'(QUEUE_DEPTH);
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

// File: hdl/cclt_back.sv
// back end: credit ring, machine state and timers
module cclt_back #(
    parameter int RING_LINES = cclt_pkg::RING_LINES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  cclt_pkg::cmd_t cmd,
    input  logic [7:0]     rx_buffer_size,
    input  logic [15:0]    poll_interval,
    input  logic [15:0]    link_timeout,
    output cclt_pkg::res_t res
);
    import cclt_pkg::*;

    localparam int RW = $clog2(RING_LINES);
    localparam int CW = $clog2(RING_LINES + 1);

    logic [7:0]    ring_reg [RING_LINES];
    logic [RW-1:0] head_reg, tail_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    credit_reg;
    logic          conn_reg, unlock_pend_reg;
    logic [3:0]    state_reg;
    logic [15:0]   poll_reg, sil_reg;

    logic [RW-1:0] head_next, tail_next;
    logic [CW-1:0] cnt_next;
    logic [7:0]    credit_next;
    logic          conn_next, unlock_pend_next;
    logic [3:0]    state_next;
    logic [15:0]   poll_next, sil_next;
    logic          push, push_ok;
    logic [7:0]    push_len, base_credit;
    logic [CW-1:0] base_cnt;
    logic [RW-1:0] base_head;
    logic [8:0]    refund_sum;

    function automatic logic [RW-1:0] inc(input logic [RW-1:0] p);
        return (32'(p) == RING_LINES - 1) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        head_next = head_reg; tail_next = tail_reg; cnt_next = cnt_reg;
        credit_next = credit_reg; conn_next = conn_reg;
        unlock_pend_next = unlock_pend_reg; state_next = state_reg;
        poll_next = poll_reg; sil_next = sil_reg;
        push = 1'b0; push_len = cmd.len;
        base_credit = credit_reg; base_cnt = cnt_reg; base_head = head_reg;
        res = '0;
        refund_sum = 9'(credit_reg) + 9'(ring_reg[tail_reg]);
        case (cmd.op)
            OP_RX_BYTE:
            begin
                sil_next = 16'd0;
                conn_next = 1'b1;
                case (cmd.kind)
                    KIND_STATUS:
                        if (cmd.tok_set)
                            state_next = cmd.tok_state;
                    KIND_OK, KIND_ERROR:
                        if (cnt_reg != '0)
                        begin
                            credit_next = refund_sum[8] ? 8'hFF : refund_sum[7:0];
                            tail_next = inc(tail_reg);
                            cnt_next = cnt_reg - 1'b1;
                        end
                    KIND_ALARM:
                        state_next = MS_ALARM;
                    KIND_BANNER:
                    begin
                        state_next = MS_UNKNOWN;
                        base_credit = rx_buffer_size;
                        base_cnt = '0;
                        base_head = '0;
                        credit_next = rx_buffer_size;
                        cnt_next = '0;
                        head_next = '0;
                        tail_next = '0;
                        if (unlock_pend_reg)
                        begin
                            unlock_pend_next = 1'b0;
                            push = 1'b1;
                            push_len = 8'd3;
                        end
                    end
                    default: ;
                endcase
            end
            OP_SEND:
                push = 1'b1;
            OP_RESET:
            begin
                credit_next = rx_buffer_size;
                cnt_next = '0; head_next = '0; tail_next = '0;
                conn_next = 1'b0;
                state_next = MS_UNKNOWN;
                unlock_pend_next = 1'b1;
                res.send_reset_byte = 1'b1;
            end
            default:
            begin
                logic [15:0] pt, st;
                pt = (poll_reg != 16'hFFFF) ? poll_reg + 16'd1 : poll_reg;
                st = (sil_reg != 16'hFFFF) ? sil_reg + 16'd1 : sil_reg;
                sil_next = st;
                if (pt >= poll_interval)
                begin
                    res.send_poll = 1'b1;
                    poll_next = 16'd0;
                end
                else
                    poll_next = pt;
                if (conn_reg && st > link_timeout)
                begin
                    conn_next = 1'b0;
                    state_next = MS_UNKNOWN;
                end
            end
        endcase
        push_ok = push && 32'(base_cnt) < RING_LINES && base_credit >= push_len;
        if (push_ok)
        begin
            head_next = inc(base_head);
            cnt_next = base_cnt + 1'b1;
            credit_next = base_credit - push_len;
        end
        res.accepted = push_ok && cmd.op == OP_SEND;
        res.send_unlock = push_ok && cmd.op == OP_RX_BYTE;
        res.line_kind = cmd.kind;
        res.machine_state = state_next;
        res.link_up = conn_next;
        res.free_credit = credit_next;
        res.lines_outstanding = 5'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0; tail_reg <= '0; cnt_reg <= '0;
            credit_reg <= 8'd128; conn_reg <= 1'b0; unlock_pend_reg <= 1'b0;
            state_reg <= MS_UNKNOWN; poll_reg <= 16'd0; sil_reg <= 16'd0;
        end
        else if (go)
        begin
            head_reg <= head_next; tail_reg <= tail_next; cnt_reg <= cnt_next;
            credit_reg <= credit_next; conn_reg <= conn_next;
            unlock_pend_reg <= unlock_pend_next; state_reg <= state_next;
            poll_reg <= poll_next; sil_reg <= sil_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && push_ok)
            ring_reg[base_head] <= push_len;
    end

endmodule

// File: hdl/char_counting_link_tracker.sv
// top level of the character counting link tracker
// One item is taken per clock cycle while full is low. The front end
// assembles received bytes into a line prefix and classifies each item on
// entry; a two-entry command queue decouples it from the back end, which
// keeps the credit ring, machine state and millisecond timers and issues one
// result beat per item into a two-entry result queue. Sustained rate is one
// item per cycle while results are popped. Each item passes the command
// queue and then, as a result, the result queue before it is on the ports.
// When the consumer stops popping, the result queue and then the command
// queue fill and full rises; it falls when popping resumes and go is high.
module char_counting_link_tracker #(
    parameter int RING_LINES   = cclt_pkg::RING_LINES_DEF,
    parameter int PREFIX_BYTES = cclt_pkg::PREFIX_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  line_length,
    output logic        empty,
    input  logic        pop,
    output logic        accepted,
    output logic [2:0]  line_kind,
    output logic [3:0]  machine_state,
    output logic        link_up,
    output logic [7:0]  free_credit,
    output logic [4:0]  lines_outstanding,
    output logic        send_unlock,
    output logic        send_poll,
    output logic        send_reset_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cclt_pkg::*;

    logic [7:0]  rxbuf_reg;
    logic [15:0] poll_int_reg, timeout_reg;

    // configuration writes always land at once
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rxbuf_reg    <= 8'd128;
            poll_int_reg <= 16'd200;
            timeout_reg  <= 16'd3000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RX_BUFFER_SIZE: rxbuf_reg    <= cfg_data[7:0];
                CFG_POLL_INTERVAL:  poll_int_reg <= cfg_data;
                CFG_LINK_TIMEOUT:   timeout_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // front end classifies the beat on acceptance
    cmd_t front_cmd, back_cmd;
    logic take;
    assign take = push && !full;

    cclt_front #(.PREFIX_BYTES(PREFIX_BYTES)) u_front (
        .clk, .rst_n, .take, .operation, .rx_byte, .line_length, .cmd(front_cmd)
    );

    // command queue between front and back
    logic cq_empty, cq_full, go;
    cclt_queue #(.WIDTH($bits(cmd_t))) u_cmdq (
        .clk, .rst_n, .wr(take), .wdata(front_cmd), .rd(go), .rdata(back_cmd),
        .full(cq_full), .empty(cq_empty)
    );
    assign full = cq_full;

    // back end runs whenever a command waits and the result queue has room
    res_t res, out_res;
    logic rq_full;
    assign go = !cq_empty && !rq_full;

    cclt_back #(.RING_LINES(RING_LINES)) u_back (
        .clk, .rst_n, .go, .cmd(back_cmd), .rx_buffer_size(rxbuf_reg),
        .poll_interval(poll_int_reg), .link_timeout(timeout_reg), .res
    );

    // result queue towards the consumer
    logic rq_pop;
    assign rq_pop = pop && !empty;
    cclt_queue #(.WIDTH($bits(res_t))) u_resq (
        .clk, .rst_n, .wr(go), .wdata(res), .rd(rq_pop), .rdata(out_res),
        .full(rq_full), .empty(empty)
    );

    assign accepted          = out_res.accepted;
    assign line_kind         = out_res.line_kind;
    assign machine_state     = out_res.machine_state;
    assign link_up           = out_res.link_up;
    assign free_credit       = out_res.free_credit;
    assign lines_outstanding = out_res.lines_outstanding;
    assign send_unlock       = out_res.send_unlock;
    assign send_poll         = out_res.send_poll;
    assign send_reset_byte   = out_res.send_reset_byte;

endmodule
